// File: design/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants for the laplacian sharpening stream.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // configuration register fields
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_start;
  } lsh_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
    logic       last_in_run;
  } lsh_out_t;

  // one queued input: sharpened value, last-row flag, end-of-frame column flag
  typedef struct packed {
    logic [7:0] val;
    logic       two;
    logic       fend;
  } lsh_entry_t;

  typedef struct packed {
    logic       valid;
    lsh_entry_t entry;
  } lsh_push_t;

  typedef struct packed {
    logic [QCW-1:0] count;
    logic           nonempty;
  } lsh_qstat_t;

endpackage

// File: design/laplacian_sharpen_stream.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_stream
// Streaming 3x3 cross-shaped sharpening filter for 8-bit grayscale video.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock while in_stall is low. The
// result for row r-1 leaves when the pixel of row r in the same column
// arrives, so nothing comes out for the first row; border positions give
// zero. On the last row every input gives two results (the delayed pixel and
// the row's own zero) through the single output port; elsewhere it is one
// per clock while out_stall is low. The line stores have no clearing pass:
// start each frame with frame_start. frame_width and frame_height must be
// written only while the stream is idle; the block does not enforce this.
module laplacian_sharpen_stream #(
  parameter int MAX_WIDTH  = lsh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsh_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lsh_pkg::lsh_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lsh_pkg::lsh_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsh_pkg::*;

  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  lsh_push_t       push;
  lsh_entry_t      head;
  lsh_qstat_t      qstat;
  logic            pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  lsh_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .qstat        (qstat),
    .push         (push)
  );

  lsh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  lsh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: design/lsh_front.sv
// ----------------------------------------------------------------------------
// lsh_front
// Position tracking, line stores and the sharpening kernel; pushes one
// queue entry for every input that produces output.
// ----------------------------------------------------------------------------
module lsh_front #(
  parameter int MAX_WIDTH  = lsh_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lsh_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lsh_pkg::lsh_in_t           in_data,
  input  logic [lsh_pkg::FW_W-1:0]   frame_width,
  input  logic [lsh_pkg::FH_W-1:0]   frame_height,
  input  lsh_pkg::lsh_qstat_t        qstat,
  output lsh_pkg::lsh_push_t         push
);
  import lsh_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic          acc;

  logic [CW-1:0] col0, c, a1;
  logic [RW-1:0] row0, r;
  logic [RW:0]   rowa;

  logic [7:0] newer_mem [MAX_WIDTH];
  logic [7:0] older_mem [MAX_WIDTH];

  logic [7:0] nrd0_r, nrd1_r, ord_r;
  logic       fw0_r, fw1_r;
  logic [7:0] fwd_pix_r, fwd_old_r;

  logic          f1_valid_r;
  logic [7:0]    f1_pix_r;
  logic [CW-1:0] f1_c_r;
  logic          f1_fs_r, f1_emit_r, f1_int_r, f1_two_r, f1_fend_r;
  logic [7:0]    left_r;

  logic [7:0]  n0_val, n1_val, o_val, above_left;
  logic [10:0] five;
  logic [9:0]  neg;
  logic [11:0] s;
  logic [7:0]  sharp;

  // clamp the configured size to the supported range
  always_comb begin
    if (32'(frame_width) < 32'd3) begin
      last_col = CW'(2);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(32'(frame_width) - 32'd1);
    end
    if (32'(frame_height) < 32'd3) begin
      last_row = RW'(2);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(32'(frame_height) - 32'd1);
    end
  end

  // room is reserved for the entry still in the kernel stage
  assign in_stall = (int'(qstat.count) + int'(f1_valid_r && f1_emit_r)) >= QDEPTH;
  assign acc      = in_valid && !in_stall;

  // position of this transaction
  always_comb begin
    col0 = in_data.frame_start ? '0 : col_r;
    row0 = in_data.frame_start ? '0 : row_r;
    if (col0 > last_col) begin
      c    = '0;
      rowa = {1'b0, row0} + (RW+1)'(1);
    end else begin
      c    = col0;
      rowa = {1'b0, row0};
    end
    r  = (rowa > {1'b0, last_row}) ? '0 : rowa[RW-1:0];
    a1 = (c == CW'(MAX_WIDTH - 1)) ? '0 : c + CW'(1);
    if (c == last_col) begin
      col_nxt = '0;
      row_nxt = (r == last_row) ? '0 : r + RW'(1);
    end else begin
      col_nxt = c + CW'(1);
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      f1_valid_r <= 1'b0;
      left_r     <= '0;
    end else begin
      f1_valid_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (f1_valid_r) begin
        left_r <= n0_val;
      end
    end
  end

  // line stores: read on accept, written in the following cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      nrd0_r    <= newer_mem[c];
      nrd1_r    <= newer_mem[a1];
      ord_r     <= older_mem[c];
      fw0_r     <= f1_valid_r && (f1_c_r == c);
      fw1_r     <= f1_valid_r && (f1_c_r == a1);
      fwd_pix_r <= f1_pix_r;
      fwd_old_r <= n0_val;
    end
    if (f1_valid_r) begin
      newer_mem[f1_c_r] <= f1_pix_r;
      older_mem[f1_c_r] <= n0_val;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_pix_r  <= in_data.pixel_in;
      f1_c_r    <= c;
      f1_fs_r   <= in_data.frame_start;
      f1_emit_r <= (r != '0);
      f1_int_r  <= (r >= RW'(2)) && (c != '0) && (c < last_col);
      f1_two_r  <= (r == last_row);
      f1_fend_r <= (c == last_col);
    end
  end

  // bypass a write landing on an address read in the same cycle
  assign n0_val     = fw0_r ? fwd_pix_r : nrd0_r;
  assign n1_val     = fw1_r ? fwd_pix_r : nrd1_r;
  assign o_val      = fw0_r ? fwd_old_r : ord_r;
  assign above_left = f1_fs_r ? '0 : left_r;

  always_comb begin
    five = {1'b0, n0_val, 2'b00} + {3'b000, n0_val};
    neg  = {2'b00, above_left} + {2'b00, n1_val} + {2'b00, o_val} + {2'b00, f1_pix_r};
    s    = {1'b0, five} - {2'b00, neg};
    if (s[11]) begin
      sharp = '0;
    end else if (s[10:8] != 3'b000) begin
      sharp = 8'hFF;
    end else begin
      sharp = s[7:0];
    end
  end

  always_comb begin
    push.valid      = f1_valid_r && f1_emit_r;
    push.entry.val  = f1_int_r ? sharp : '0;
    push.entry.two  = f1_two_r;
    push.entry.fend = f1_fend_r;
  end

endmodule

// File: design/lsh_queue.sv
// ----------------------------------------------------------------------------
// lsh_queue
// Small first-in first-out buffer between the kernel and the output side.
// ----------------------------------------------------------------------------
module lsh_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsh_pkg::lsh_push_t   push,
  input  logic                 pop,
  output lsh_pkg::lsh_entry_t  head,
  output lsh_pkg::lsh_qstat_t  qstat
);
  import lsh_pkg::*;

  lsh_entry_t     buf_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push.valid) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= (32'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      buf_r[wr_ptr_r] <= push.entry;
    end
  end

  assign head           = buf_r[rd_ptr_r];
  assign qstat.count    = count_r;
  assign qstat.nonempty = (count_r != '0);

endmodule

// File: design/lsh_back.sv
// ----------------------------------------------------------------------------
// lsh_back
// Output side: turns each queue entry into one result, or two on the
// last row (the delayed pixel, then the row's own zero border result).
// ----------------------------------------------------------------------------
module lsh_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsh_pkg::lsh_entry_t  head,
  input  lsh_pkg::lsh_qstat_t  qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsh_pkg::lsh_out_t    out_data
);
  import lsh_pkg::*;

  logic second_r, second_nxt;
  logic xfer;

  assign out_valid = qstat.nonempty;
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && (second_r || !head.two);

  always_comb begin
    second_nxt = second_r;
    if (xfer) begin
      second_nxt = head.two && !second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
    end else begin
      second_r <= second_nxt;
    end
  end

  always_comb begin
    if (second_r) begin
      out_data.pixel_out   = '0;
      out_data.frame_end   = head.fend;
      out_data.last_in_run = 1'b1;
    end else begin
      out_data.pixel_out   = head.val;
      out_data.frame_end   = 1'b0;
      out_data.last_in_run = !head.two;
    end
  end

endmodule
